/* rtl/core/set_associative_lru_cache_sim_unit_assert.svh */
// assertion macros for the lru cache tag unit
`ifndef SET_ASSOCIATIVE_LRU_CACHE_SIM_UNIT_ASSERT_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_SIM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle
`define SALC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("cache unit assertion failed");

// consequent must hold in the next cycle
`define SALC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("cache unit assertion failed");

`else

`define SALC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SALC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* rtl/core/salc_pkg.sv */
// shared types and constants for the lru cache tag unit
`default_nettype none

package salc_pkg;

  localparam int DEF_MAX_SET_BITS  = 6;
  localparam int DEF_MAX_WAYS      = 8;
  localparam int DEF_ADDRESS_WIDTH = 64;
  localparam int DEF_COUNT_WIDTH   = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS    = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_WAYS        = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic     hit;
    logic     evict;
    outcome_e outcome;
  } lookup_t;

endpackage

`default_nettype wire

/* rtl/core/set_associative_lru_cache_sim_unit.sv */
// top level of the set-associative lru cache tag unit
`default_nettype none

`include "set_associative_lru_cache_sim_unit_assert.svh"

// Tag-only set-associative cache with lru replacement. Each set is one row of
// the tag ram holding valid, rank and tag of every way. A load or store reads
// the set row (registered ram read) as the request is taken; in the lookup
// state it compares all ways and writes the updated row back. A modify adds
// a second state, whose (store) result is always a hit on the same way. Busy
// stays high in the lookup and second states, so no new request is taken
// meanwhile. Results show for one cycle with done_o, the cycle after the
// state that made them; the receiver cannot stall them. An op of 3 is taken
// and dropped. A configuration write of a known register invalidates every
// set at once through per-set valid flags (no clearing pass); counters are kept.
module set_associative_lru_cache_sim_unit #(
  parameter int MAX_SET_BITS  = salc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS      = salc_pkg::DEF_MAX_WAYS,
  parameter int ADDRESS_WIDTH = salc_pkg::DEF_ADDRESS_WIDTH,
  parameter int COUNT_WIDTH   = salc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      op_i,
  input  logic [ADDRESS_WIDTH-1:0]        address_i,
  input  logic                            cfg_we_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                            done_o,
  output logic [1:0]                      outcome_o,
  output logic [5:0]                      set_index_o,
  output logic [2:0]                      way_o,
  output logic [COUNT_WIDTH-1:0]          hits_total_o,
  output logic [COUNT_WIDTH-1:0]          misses_total_o,
  output logic [COUNT_WIDTH-1:0]          evictions_total_o,
  output logic                            last_o
);

  import salc_pkg::*;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int EW       = 1 + RW + ADDRESS_WIDTH;
  localparam int ROW_W    = MAX_WAYS * EW;
  localparam int WAYS_W   = $clog2(MAX_WAYS + 1);
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOK   = 2'd1;
  localparam logic [1:0] ST_SECOND = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [2:0]               sib_q;
  logic [5:0]               bob_q;
  logic [3:0]               wiu_q;
  logic [NUM_SETS-1:0]      rowvld_q;
  logic [SET_W-1:0]         set_q;
  logic [ADDRESS_WIDTH-1:0] tag_q;
  logic                     mod_q;
  logic [COUNT_WIDTH-1:0]   hits_q, miss_q, evict_q;
  logic                     done_q, last_q;
  outcome_e                 outcome_q;
  logic [SET_W-1:0]         oset_q;
  logic [WAY_W-1:0]         oway_q;

  logic                     accept, op_ok, go;
  logic [2:0]               s_eff;
  logic [WAYS_W-1:0]        ways_eff;
  logic [SET_W-1:0]         set_mask;
  logic [ADDRESS_WIDTH-1:0] addr_sh;
  logic [SET_W-1:0]         set_in;
  logic [ADDRESS_WIDTH-1:0] tag_in;
  logic [ROW_W-1:0]         row_rd, row_wr;
  logic [WAY_W-1:0]         look_way;
  lookup_t                  look;
  logic                     in_look;

  // effective configuration with out-of-range values clamped
  assign s_eff    = (sib_q > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : sib_q;
  assign ways_eff = (wiu_q == 4'd0)    ? WAYS_W'(1) :
                    (wiu_q > MAX_WAYS) ? WAYS_W'(MAX_WAYS) : WAYS_W'(wiu_q);

  assign set_mask = ~({SET_W{1'b1}} << s_eff);
  assign addr_sh  = address_i >> bob_q;
  assign set_in   = addr_sh[SET_W-1:0] & set_mask;
  assign tag_in   = address_i >> (7'(s_eff) + 7'(bob_q));

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign op_ok   = (op_i == OP_LOAD) || (op_i == OP_STORE) || (op_i == OP_MODIFY);
  assign go      = accept && op_ok;
  assign in_look = (state_q == ST_LOOK);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (go) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = mod_q ? ST_SECOND : ST_IDLE;
      end
      ST_SECOND: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (in_look),
    .waddr_i (set_q),
    .wdata_i (row_wr),
    .re_i    (go),
    .raddr_i (set_in),
    .rdata_o (row_rd)
  );

  salc_way_logic #(
    .MAX_WAYS      (MAX_WAYS),
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_way_logic (
    .row_ok_i (rowvld_q[set_q]),
    .row_i    (row_rd),
    .tag_i    (tag_q),
    .ways_i   (ways_eff),
    .row_o    (row_wr),
    .way_o    (look_way),
    .look_o   (look)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      sib_q    <= '0;
      bob_q    <= '0;
      wiu_q    <= 4'd1;
      rowvld_q <= '0;
      hits_q   <= '0;
      miss_q   <= '0;
      evict_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= in_look || (state_q == ST_SECOND);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SET_BITS: begin
            sib_q    <= cfg_wdata_i[2:0];
            rowvld_q <= '0;
          end
          REG_OFFSET_BITS: begin
            bob_q    <= cfg_wdata_i;
            rowvld_q <= '0;
          end
          REG_WAYS: begin
            wiu_q    <= cfg_wdata_i[3:0];
            rowvld_q <= '0;
          end
          default: begin
          end
        endcase
      end
      if (in_look) begin
        rowvld_q[set_q] <= 1'b1;
        if (look.hit) begin
          hits_q <= (hits_q == '1) ? hits_q : hits_q + 1'b1;
        end else begin
          miss_q <= (miss_q == '1) ? miss_q : miss_q + 1'b1;
        end
        if (look.evict) begin
          evict_q <= (evict_q == '1) ? evict_q : evict_q + 1'b1;
        end
      end
      // store half of a modify hits the line just touched
      if (state_q == ST_SECOND) begin
        hits_q <= (hits_q == '1) ? hits_q : hits_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      set_q <= set_in;
      tag_q <= tag_in;
      mod_q <= (op_i == OP_MODIFY);
    end
    if (in_look) begin
      outcome_q <= look.outcome;
      oset_q    <= set_q;
      oway_q    <= look_way;
      last_q    <= ~mod_q;
    end else if (state_q == ST_SECOND) begin
      outcome_q <= OUT_HIT;
      last_q    <= 1'b1;
    end
  end

  assign done_o            = done_q;
  assign outcome_o         = outcome_q;
  assign set_index_o       = 6'(oset_q);
  assign way_o             = 3'(oway_q);
  assign hits_total_o      = hits_q;
  assign misses_total_o    = miss_q;
  assign evictions_total_o = evict_q;
  assign last_o            = last_q;

  `SALC_ASSERT_NEXT(a_look_gives_result, clk_i, rst_ni, in_look, done_o)
  `SALC_ASSERT_NEXT(a_modify_second_hit, clk_i, rst_ni, done_o && !last_o,
                    done_o && last_o && (outcome_o == OUT_HIT))
  `SALC_ASSERT_SAME(a_first_of_two_busy, clk_i, rst_ni, done_o && !last_o, busy)
  `SALC_ASSERT_NEXT(a_bad_op_dropped, clk_i, rst_ni, accept && !op_ok, !busy && !done_o)

endmodule

`default_nettype wire

/* rtl/core/salc_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/salc_way_logic.sv */
// tag compare, victim choice and lru rank update for one set row
`default_nettype none

module salc_way_logic #(
  parameter int MAX_WAYS      = 8,
  parameter int ADDRESS_WIDTH = 64,
  localparam int RW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int EW     = 1 + RW + ADDRESS_WIDTH,
  localparam int ROW_W  = MAX_WAYS * EW,
  localparam int WAYS_W = $clog2(MAX_WAYS + 1),
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic                     row_ok_i,
  input  logic [ROW_W-1:0]         row_i,
  input  logic [ADDRESS_WIDTH-1:0] tag_i,
  input  logic [WAYS_W-1:0]        ways_i,
  output logic [ROW_W-1:0]         row_o,
  output logic [WAY_W-1:0]         way_o,
  output salc_pkg::lookup_t        look_o
);

  import salc_pkg::*;

  localparam int ORW = RW + 1;

  logic                     v_e   [MAX_WAYS];
  logic [RW-1:0]            r_e   [MAX_WAYS];
  logic [ADDRESS_WIDTH-1:0] t_e   [MAX_WAYS];
  logic [MAX_WAYS-1:0]      in_use;
  logic [MAX_WAYS-1:0]      hit_vec;
  logic [MAX_WAYS-1:0]      free_vec;
  logic [MAX_WAYS-1:0]      old_vec;
  logic [WAY_W-1:0]         hit_way;
  logic [WAY_W-1:0]         free_way;
  logic [WAY_W-1:0]         old_way;
  logic [WAY_W-1:0]         sel_way;
  logic                     any_hit;
  logic                     any_free;
  logic [ORW-1:0]           old_rank;
  logic [RW-1:0]            lru_rank;

  assign lru_rank = RW'(ways_i - WAYS_W'(1));

  // unpack; a row never written since the last flush reads as empty
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      v_e[i]      = row_ok_i & row_i[i*EW + EW - 1];
      r_e[i]      = row_ok_i ? row_i[i*EW + ADDRESS_WIDTH +: RW] : '0;
      t_e[i]      = row_i[i*EW +: ADDRESS_WIDTH];
      in_use[i]   = (WAYS_W'(i) < ways_i);
      hit_vec[i]  = in_use[i] & v_e[i] & (t_e[i] == tag_i);
      free_vec[i] = in_use[i] & ~v_e[i];
      // valid ranks form a permutation, so the oldest has rank ways-1
      old_vec[i]  = in_use[i] & (r_e[i] == lru_rank);
    end
  end

  // lowest-numbered way wins in each search
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    old_way  = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WAY_W'(i);
      end
      if (free_vec[i]) begin
        free_way = WAY_W'(i);
      end
      if (old_vec[i]) begin
        old_way = WAY_W'(i);
      end
    end
  end

  assign any_hit  = |hit_vec;
  assign any_free = |free_vec;

  always_comb begin
    if (any_hit) begin
      sel_way        = hit_way;
      old_rank       = {1'b0, r_e[hit_way]};
      look_o.outcome = OUT_HIT;
    end else if (any_free) begin
      sel_way        = free_way;
      old_rank       = ORW'(MAX_WAYS);
      look_o.outcome = OUT_FILL;
    end else begin
      sel_way        = old_way;
      old_rank       = {1'b0, r_e[old_way]};
      look_o.outcome = OUT_EVICT;
    end
    look_o.hit   = any_hit;
    look_o.evict = ~any_hit & ~any_free;
  end

  assign way_o = sel_way;

  // chosen way becomes most recent, younger valid ways age by one
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WAY_W'(i) == sel_way) begin
        row_o[i*EW +: EW] = {1'b1, {RW{1'b0}}, tag_i};
      end else if (v_e[i] && ({1'b0, r_e[i]} < old_rank)) begin
        row_o[i*EW +: EW] = {1'b1, RW'(r_e[i] + 1'b1), t_e[i]};
      end else begin
        row_o[i*EW +: EW] = {v_e[i], r_e[i], t_e[i]};
      end
    end
  end

endmodule

`default_nettype wire
